[rtl/core/cle_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg
// Shared constants for the console line editor: byte codes, word kinds,
// result types and configuration register indexes.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int LINE_CAPACITY_DEF = 16;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int TYPE_W  = 2;
  localparam int LEN_W   = 5;
  localparam int CFG_IDX_W = 2;

  // Input word kinds.
  localparam logic [KIND_W-1:0] KIND_TYPED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK  = 2'd2;

  // Result types.
  localparam logic [TYPE_W-1:0] TYPE_ECHO = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_LINE = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_DATA = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_ONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_TWO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KILL      = 2'd2;

  // Fixed byte codes.
  localparam logic [BYTE_W-1:0] BYTE_CR  = 8'd13;
  localparam logic [BYTE_W-1:0] BYTE_LF  = 8'd10;
  localparam logic [BYTE_W-1:0] BYTE_SP  = 8'd32;
  localparam logic [BYTE_W-1:0] BYTE_BS  = 8'd8;
  localparam logic [BYTE_W-1:0] BYTE_NUL = 8'd0;

  // Register reset values.
  localparam logic [BYTE_W-1:0] ERASE_ONE_RST = 8'd8;
  localparam logic [BYTE_W-1:0] ERASE_TWO_RST = 8'd127;
  localparam logic [BYTE_W-1:0] KILL_RST      = 8'd21;

endpackage

[rtl/core/cle_line_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_line_mem
// Line store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cle_line_mem #(
  parameter int DEPTH = cle_pkg::LINE_CAPACITY_DEF + 1,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [cle_pkg::BYTE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [cle_pkg::BYTE_W-1:0] rd_data
);
  import cle_pkg::*;

  logic [BYTE_W-1:0] mem_r [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/console_line_editor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_line_editor
// Console line gathering with erase and kill editing and line read-out.
// ----------------------------------------------------------------------------
// Words are taken one at a time; in_ready is high only while the sequencer is
// idle. A typed byte that is stored or ignored gives no result. Each result
// is loaded into the output register once that is free, so an erase of a
// stored byte emits backspace, space, backspace (after a leading space for the
// first erase byte), a kill emits that triple per stored byte, and a carriage
// return emits a line feed. Read and peek words fetch from the line memory at
// accept and present the byte from the data state. The output register lets
// the next word be accepted while the final result of the previous one waits for out_ready.
module console_line_editor #(
  parameter int LINE_CAPACITY = cle_pkg::LINE_CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cle_pkg::KIND_W-1:0]    in_kind,
  input  logic [cle_pkg::BYTE_W-1:0]    in_typed_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cle_pkg::BYTE_W-1:0]    out_byte,
  output logic [cle_pkg::TYPE_W-1:0]    out_type,
  output logic [cle_pkg::LEN_W-1:0]     out_line_length,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cle_pkg::BYTE_W-1:0]    cfg_data
);
  import cle_pkg::*;

  localparam int DEPTH = LINE_CAPACITY + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [LEN_W-1:0] CAP = LEN_W'(LINE_CAPACITY);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SP   = 3'd1;
  localparam logic [2:0] S_DROP = 3'd2;
  localparam logic [2:0] S_LF   = 3'd3;
  localparam logic [2:0] S_DATA = 3'd4;

  localparam logic [1:0] PH_BS1 = 2'd0;
  localparam logic [1:0] PH_SP  = 2'd1;
  localparam logic [1:0] PH_BS2 = 2'd2;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic              kill_r, kill_nxt;
  logic              zero_r, zero_nxt;
  logic [LEN_W-1:0]  fc_r, fc_nxt;
  logic [LEN_W-1:0]  rp_r, rp_nxt;
  logic              done_r, done_nxt;
  logic [BYTE_W-1:0] erase_one_r, erase_two_r, kill_char_r;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [TYPE_W-1:0] out_type_r;
  logic [LEN_W-1:0]  out_len_r;
  logic              out_last_r;

  logic              ld;
  logic [BYTE_W-1:0] ld_byte;
  logic [TYPE_W-1:0] ld_type;
  logic [LEN_W-1:0]  ld_len;
  logic              ld_last;

  logic              out_free;
  logic [LEN_W-1:0]  fc_eff;
  logic [LEN_W-1:0]  fc_clamp;
  logic              rd_ok;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              rd_en;
  logic [BYTE_W-1:0] rd_data;

  cle_line_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rp_r[AW-1:0]),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  // A typed byte after a completed line starts a fresh line.
  assign fc_eff    = done_r ? '0 : fc_r;
  assign fc_clamp  = (fc_eff > CAP) ? CAP : fc_eff;
  assign rd_ok     = done_r && (rp_r <= fc_r);

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    kill_nxt  = kill_r;
    zero_nxt  = zero_r;
    fc_nxt    = fc_r;
    rp_nxt    = rp_r;
    done_nxt  = done_r;
    ld        = 1'b0;
    ld_byte   = BYTE_NUL;
    ld_type   = TYPE_ECHO;
    ld_len    = fc_r;
    ld_last   = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = fc_eff[AW-1:0];
    wr_data   = in_typed_byte;
    rd_en     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            KIND_TYPED: begin
              if (done_r) begin
                done_nxt = 1'b0;
                fc_nxt   = '0;
                rp_nxt   = '0;
              end
              if (in_typed_byte == BYTE_CR) begin
                wr_en     = 1'b1;
                wr_addr   = fc_clamp[AW-1:0];
                wr_data   = BYTE_CR;
                fc_nxt    = fc_clamp;
                rp_nxt    = '0;
                done_nxt  = 1'b1;
                state_nxt = S_LF;
              end else if (in_typed_byte == erase_one_r) begin
                state_nxt = S_SP;
              end else if (in_typed_byte == erase_two_r) begin
                if (fc_eff != '0) begin
                  kill_nxt  = 1'b0;
                  ph_nxt    = PH_BS1;
                  state_nxt = S_DROP;
                end
              end else if (in_typed_byte == kill_char_r) begin
                if (fc_eff != '0) begin
                  kill_nxt  = 1'b1;
                  ph_nxt    = PH_BS1;
                  state_nxt = S_DROP;
                end
              end else if (fc_eff < CAP) begin
                wr_en  = 1'b1;
                fc_nxt = fc_eff + LEN_W'(1);
              end
            end
            KIND_READ, KIND_PEEK: begin
              rd_en    = rd_ok;
              zero_nxt = !rd_ok || ((in_kind == KIND_READ) && (rp_r >= fc_r));
              if ((in_kind == KIND_READ) && rd_ok && (rp_r < fc_r)) begin
                rp_nxt = rp_r + LEN_W'(1);
              end
              state_nxt = S_DATA;
            end
            default: begin
            end
          endcase
        end
      end
      S_SP: begin
        if (out_free) begin
          ld       = 1'b1;
          ld_byte  = BYTE_SP;
          ld_last  = (fc_r == '0);
          kill_nxt = 1'b0;
          ph_nxt   = PH_BS1;
          state_nxt = (fc_r != '0) ? S_DROP : S_IDLE;
        end
      end
      S_DROP: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_byte = (ph_r == PH_SP) ? BYTE_SP : BYTE_BS;
          if (ph_r == PH_BS1) begin
            // The byte leaves the line with the first backspace.
            fc_nxt = fc_r - LEN_W'(1);
            ld_len = fc_r - LEN_W'(1);
          end
          ld_last = (ph_r == PH_BS2) && (!kill_r || (fc_r == '0));
          if (ph_r == PH_BS2) begin
            ph_nxt    = PH_BS1;
            state_nxt = ld_last ? S_IDLE : S_DROP;
          end else begin
            ph_nxt = ph_r + 2'd1;
          end
        end
      end
      S_LF: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_byte   = BYTE_LF;
          ld_type   = TYPE_LINE;
          ld_last   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DATA: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_byte   = zero_r ? BYTE_NUL : rd_data;
          ld_type   = TYPE_DATA;
          ld_last   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= PH_BS1;
      kill_r      <= 1'b0;
      zero_r      <= 1'b0;
      fc_r        <= '0;
      rp_r        <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      kill_r  <= kill_nxt;
      zero_r  <= zero_nxt;
      fc_r    <= fc_nxt;
      rp_r    <= rp_nxt;
      done_r  <= done_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_byte_r <= ld_byte;
      out_type_r <= ld_type;
      out_len_r  <= ld_len;
      out_last_r <= ld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      erase_one_r <= ERASE_ONE_RST;
      erase_two_r <= ERASE_TWO_RST;
      kill_char_r <= KILL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ERASE_ONE: erase_one_r <= cfg_data;
        CFG_ERASE_TWO: erase_two_r <= cfg_data;
        CFG_KILL:      kill_char_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_type        = out_type_r;
  assign out_line_length = out_len_r;
  assign out_last        = out_last_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= CAP)
    else $error("fill count above line capacity");

  a_read_within_line: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rp_r <= fc_r))
    else $error("read position beyond completed line");

  a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DROP) && (ph_r == PH_BS1) |-> (fc_r != '0))
    else $error("erase started on an empty line");

  a_line_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_type_r == TYPE_LINE) |-> out_last_r)
    else $error("line completion word not marked last");

endmodule

[bench/console_line_editor_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_line_editor_tb
// Self-checking bench for the console line editor. A queue of console words
// (typed bytes, reads, peeks and ignored kinds) feeds a bursty driver. An
// in-bench line model predicts every echo, line completion and read result.
// A monitor behind a stalling receiver checks each result in order. The run
// walks through several erase and kill register settings, extremes included.
// ----------------------------------------------------------------------------
module console_line_editor_tb;
  import cle_pkg::*;

  localparam int CAP            = LINE_CAPACITY_DEF;
  localparam int SETTLE_CYCLES  = 64;
  localparam int RAND_PER_PHASE = 44;
  localparam int HOLD_AFTER     = 60;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_MIN_QUEUE = 8;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] ch;
  } keystroke_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [TYPE_W-1:0] rtype;
    logic [LEN_W-1:0]  len;
    logic              last;
  } console_reply_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [KIND_W-1:0]    in_kind = KIND_TYPED;
  logic [BYTE_W-1:0]    in_typed_byte = BYTE_NUL;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [BYTE_W-1:0]    out_byte;
  logic [TYPE_W-1:0]    out_type;
  logic [LEN_W-1:0]     out_line_length;
  logic                 out_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ERASE_ONE;
  logic [BYTE_W-1:0]    cfg_data = BYTE_NUL;

  console_line_editor dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_typed_byte   (in_typed_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_type        (out_type),
    .out_line_length (out_line_length),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // Line model state and its copy of the editing registers.
  logic [BYTE_W-1:0] line_mem [0:CAP];
  int                fill = 0;
  int                rd_pos = 0;
  logic              line_done = 1'b0;
  logic [BYTE_W-1:0] erase_one_q = ERASE_ONE_RST;
  logic [BYTE_W-1:0] erase_two_q = ERASE_TWO_RST;
  logic [BYTE_W-1:0] kill_q = KILL_RST;

  keystroke_t     strokes_to_send [$];
  console_reply_t pending_replies [$];

  int errors = 0;
  int words_sent = 0;
  int replies_checked = 0;
  int cfg_writes = 0;
  int settings_run = 0;
  int burst_left = 0;
  int gap_left = 0;
  int rx_cyc = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  task automatic push_reply(input logic [BYTE_W-1:0] b, input logic [TYPE_W-1:0] t);
    console_reply_t r;
    r.data  = b;
    r.rtype = t;
    r.len   = LEN_W'(fill);
    r.last  = 1'b0;
    pending_replies.push_back(r);
  endtask

  task automatic rub_out();
    if (fill > 0) begin
      fill--;
      push_reply(BYTE_BS, TYPE_ECHO);
      push_reply(BYTE_SP, TYPE_ECHO);
      push_reply(BYTE_BS, TYPE_ECHO);
    end
  endtask

  task automatic compute_replies(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] ch);
    int             n0;
    logic [BYTE_W-1:0] b;
    console_reply_t r;
    n0 = pending_replies.size();
    if (k == KIND_TYPED) begin
      // The first byte after a completed line opens a fresh one.
      if (line_done) begin
        line_done = 1'b0;
        fill = 0;
        rd_pos = 0;
      end
      if (ch == BYTE_CR) begin
        if (fill > CAP) fill = CAP;
        line_mem[fill] = BYTE_CR;
        rd_pos = 0;
        line_done = 1'b1;
        push_reply(BYTE_LF, TYPE_LINE);
      end else if (ch == erase_one_q) begin
        push_reply(BYTE_SP, TYPE_ECHO);
        rub_out();
      end else if (ch == erase_two_q) begin
        rub_out();
      end else if (ch == kill_q) begin
        while (fill > 0) rub_out();
      end else if (fill < CAP) begin
        line_mem[fill] = ch;
        fill++;
      end
    end else if (k == KIND_READ || k == KIND_PEEK) begin
      b = BYTE_NUL;
      if (line_done && rd_pos <= fill && rd_pos <= CAP) begin
        if (k == KIND_PEEK) begin
          b = line_mem[rd_pos];
        end else if (rd_pos < fill) begin
          b = line_mem[rd_pos];
          rd_pos++;
        end
      end
      push_reply(b, TYPE_DATA);
    end
    if (pending_replies.size() > n0) begin
      r = pending_replies.pop_back();
      r.last = 1'b1;
      pending_replies.push_back(r);
    end
  endtask

  task automatic push_stroke(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] ch);
    keystroke_t s;
    s.kind = k;
    s.ch   = ch;
    strokes_to_send.push_back(s);
  endtask

  task automatic queue_directed();
    push_stroke(KIND_READ, BYTE_NUL);
    push_stroke(KIND_PEEK, BYTE_NUL);
    push_stroke(KIND_NONE, 8'hFF);
    push_stroke(KIND_TYPED, erase_one_q);
    push_stroke(KIND_TYPED, erase_two_q);
    push_stroke(KIND_TYPED, kill_q);
    push_stroke(KIND_TYPED, 8'h00);
    push_stroke(KIND_TYPED, 8'hFF);
    push_stroke(KIND_TYPED, 8'h41);
    push_stroke(KIND_TYPED, erase_one_q);
    push_stroke(KIND_TYPED, erase_two_q);
    push_stroke(KIND_TYPED, 8'h42);
    push_stroke(KIND_TYPED, 8'h43);
    push_stroke(KIND_TYPED, kill_q);
    push_stroke(KIND_TYPED, 8'h55);
    push_stroke(KIND_TYPED, 8'hAA);
    push_stroke(KIND_TYPED, BYTE_CR);
    push_stroke(KIND_PEEK, BYTE_NUL);
    push_stroke(KIND_READ, BYTE_NUL);
    push_stroke(KIND_READ, BYTE_NUL);
    // Past the end: read gives zero and stays, peek shows the stored return.
    push_stroke(KIND_READ, BYTE_NUL);
    push_stroke(KIND_PEEK, BYTE_NUL);
    push_stroke(KIND_TYPED, BYTE_CR);
    push_stroke(KIND_READ, BYTE_NUL);
    push_stroke(KIND_PEEK, BYTE_NUL);
  endtask

  // Mostly well-formed lines with random content and edits, plus some noise.
  task automatic queue_random(input int budget);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          push_stroke(KIND_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)));
          sent++;
        end
      end else begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 8);
        for (int i = 0; i < len; i++) begin
          pick = $urandom_range(0, 19);
          if (pick == 0) push_stroke(KIND_TYPED, erase_one_q);
          else if (pick == 1) push_stroke(KIND_TYPED, erase_two_q);
          else if (pick == 2) push_stroke(KIND_TYPED, kill_q);
          else push_stroke(KIND_TYPED, BYTE_W'($urandom_range(0, 255)));
          sent++;
        end
        if (len >= CAP && $urandom_range(0, 1) == 0) begin
          push_stroke(KIND_TYPED, kill_q);
          sent++;
        end
        push_stroke(KIND_TYPED, BYTE_CR);
        sent++;
        repeat ($urandom_range(0, len + 3)) begin
          push_stroke(($urandom_range(0, 2) != 0) ? KIND_READ : KIND_PEEK,
                      BYTE_W'($urandom_range(0, 255)));
          sent++;
        end
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ERASE_ONE: erase_one_q = val;
      CFG_ERASE_TWO: erase_two_q = val;
      CFG_KILL:      kill_q = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Words that cause no result may still be in flight, hence the settle time
  // and the second look once it has passed.
  task automatic wait_idle();
    do begin
      while (strokes_to_send.size() != 0 || in_valid || pending_replies.size() != 0)
        @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (strokes_to_send.size() != 0 || in_valid || pending_replies.size() != 0);
  endtask

  // Driver: bursts of words separated by random gaps.
  always @(posedge clk) begin
    keystroke_t s;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        compute_replies(in_kind, in_typed_byte);
        words_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (strokes_to_send.size() != 0) begin
          s = strokes_to_send.pop_front();
          in_valid      <= 1'b1;
          in_kind       <= s.kind;
          in_typed_byte <= s.ch;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: rotating stall patterns and one long hold-off, started while
  // the sender still has plenty of words to offer.
  always @(posedge clk) begin
    if (rst_n) begin
      rx_cyc++;
      if (!hold_done && replies_checked >= HOLD_AFTER &&
          strokes_to_send.size() > HOLD_MIN_QUEUE) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case ((rx_cyc / 150) % 4)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ((rx_cyc % 4) == 0);
          default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    console_reply_t r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t ns: unexpected result byte=%0d type=%0d len=%0d last=%0d",
                 $time, out_byte, out_type, out_line_length, out_last);
        errors++;
      end else begin
        r = pending_replies.pop_front();
        if ({out_byte, out_type, out_line_length, out_last} !==
            {r.data, r.rtype, r.len, r.last}) begin
          $display("%0t ns: mismatch, expected byte=%0d type=%0d len=%0d last=%0d,",
                   $time, r.data, r.rtype, r.len, r.last);
          $display("    got byte=%0d type=%0d len=%0d last=%0d",
                   out_byte, out_type, out_line_length, out_last);
          errors++;
        end
      end
      replies_checked++;
    end
  end

  initial begin
    logic [BYTE_W-1:0] e1;
    logic [BYTE_W-1:0] e2;
    logic [BYTE_W-1:0] kv;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    queue_directed();
    queue_random(RAND_PER_PHASE);
    settings_run++;
    wait_idle();
    for (int p = 0; p < 4; p++) begin
      case (p)
        // The kill byte equals the return, so the return must win.
        0: begin e1 = 8'h00; e2 = 8'hFF; kv = BYTE_CR; end
        1: begin e1 = 8'hFF; e2 = 8'h00; kv = 8'h00; end
        // All three equal unless replaced by random values: the first erase has priority.
        2: begin e1 = 8'h41; e2 = 8'h41; kv = 8'h41; end
        default: begin e1 = ERASE_ONE_RST; e2 = ERASE_TWO_RST; kv = KILL_RST; end
      endcase
      if (p == 2 && $urandom_range(0, 1) == 0) begin
        e1 = BYTE_W'($urandom_range(0, 255));
        e2 = BYTE_W'($urandom_range(0, 255));
        kv = BYTE_W'($urandom_range(0, 255));
      end
      write_reg(CFG_ERASE_ONE, e1);
      write_reg(CFG_ERASE_TWO, e2);
      write_reg(CFG_KILL, kv);
      queue_random(RAND_PER_PHASE);
      settings_run++;
      wait_idle();
    end
    $display("Run covered %0d console words and %0d checked results under %0d register settings.",
             words_sent, replies_checked, settings_run);
    $display("It made %0d register writes and one receiver hold-off of %0d cycles.",
             cfg_writes, HOLD_CYCLES);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timeout with %0d results outstanding", pending_replies.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
